// File: design/msps_pkg.sv
`timescale 1ns / 1ps
// Package for the min-score priority set: field widths, op and status codes,
// word types, cell control and state machine types. Used by the cell, the top level and the testbench.
package msps_pkg;

	localparam int INDEX_W      = 16;
	localparam int SCORE_W      = 16;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOEFFECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [INDEX_W-1:0] match_index;
		logic [SCORE_W-1:0] match_score;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
		logic                top_valid;
		logic [INDEX_W-1:0]  top_index;
		logic [SCORE_W-1:0]  top_score;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] index;
		logic [SCORE_W-1:0] score;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_ERASE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic [INDEX_W-1:0] key;
		logic [SCORE_W-1:0] score;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_APPLY,
		S_RESP
	} state_t;

endpackage

// File: design/msps_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one entry and moves it to a neighbor.
// Depends on msps_pkg for the entry and control types.
module msps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  msps_pkg::cell_ctrl_t ctrl,
	input  msps_pkg::entry_t    left_entry,
	input  msps_pkg::entry_t    right_entry,
	input  logic                left_le,
	input  logic                shift_hit,
	output msps_pkg::entry_t    entry,
	output logic                le,
	output logic                hit
);

	msps_pkg::entry_t entry_q;
	msps_pkg::entry_t new_entry;

	always_comb begin
		hit = entry_q.valid && (entry_q.index == ctrl.key);
		le  = entry_q.valid && (entry_q.score <= ctrl.score);
		new_entry.valid = 1'b1;
		new_entry.index = ctrl.key;
		new_entry.score = ctrl.score;
	end

	// Held entries are sorted, so le is true on a leading run of cells. The
	// first cell past that run takes the new word; later cells take the left one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			unique case (ctrl.cmd)
				msps_pkg::CMD_HOLD: begin
				end
				msps_pkg::CMD_INSERT: begin
					if (!le) begin
						if (left_le) begin
							entry_q <= new_entry;
						end else begin
							entry_q <= left_entry;
						end
					end
				end
				msps_pkg::CMD_ERASE: begin
					if (shift_hit) begin
						entry_q <= right_entry;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign entry = entry_q;

endmodule

// File: design/msps_scan.sv
`timescale 1ns / 1ps
// Prefix OR over the per-cell hit flags, one doubling step per cycle while step is high.
// Self-contained; used by the top level to find the cells behind an erased one.
module msps_scan #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                step,
	input  logic [CAPACITY-1:0] hits,
	output logic [CAPACITY-1:0] pfx,
	output logic                last
);

	localparam int LEVELS = $clog2(CAPACITY);
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic [CAPACITY-1:0] pfx_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [CAPACITY-1:0] shifted;

	assign shifted = pfx_q << (32'd1 << lvl_q);
	assign last    = (lvl_q == LVL_W'(LEVELS - 1));
	assign pfx     = pfx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_q <= '0;
			lvl_q <= '0;
		end else if (load) begin
			pfx_q <= hits;
			lvl_q <= '0;
		end else if (step) begin
			pfx_q <= pfx_q | shifted;
			if (!last) begin
				lvl_q <= lvl_q + LVL_W'(1);
			end
		end
	end

endmodule

// File: design/min_score_priority_set_top.sv
`timescale 1ns / 1ps
// Min-score priority set: a chain of CAPACITY cells sorted by score.
// Each word passes through the states load, scan, apply and respond; the doubling
// prefix scan in the scan state finds the cells behind a hit.
// One word at a time: busy stays high until the result cycle, so a new word is
// taken only after the last one is through. The receiver cannot stall done.
// Asynchronous reset empties every cell; no clearing pass is needed.
module min_score_priority_set_top #(
	parameter int CAPACITY = msps_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  msps_pkg::item_t   item,
	output logic              done,
	output msps_pkg::result_t result
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int LEVELS = $clog2(CAPACITY);
	localparam int LAT    = LEVELS + 4;

	msps_pkg::state_t   state_q, state_d;
	msps_pkg::item_t    item_q;
	msps_pkg::result_t  result_q;
	msps_pkg::cell_ctrl_t ctrl;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [1:0]         status_q, status_d;
	logic               done_q;
	logic               scan_load, scan_step, scan_last;
	logic               present;

	msps_pkg::entry_t    entries [CAPACITY];
	logic [CAPACITY-1:0] le_v;
	logic [CAPACITY-1:0] hit_v;
	logic [CAPACITY-1:0] pfx_v;

	msps_scan #(
		.CAPACITY(CAPACITY)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (scan_load),
		.step  (scan_step),
		.hits  (hit_v),
		.pfx   (pfx_v),
		.last  (scan_last)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		msps_pkg::entry_t left_e, right_e;
		logic             left_le;

		if (i == 0) begin : g_first
			assign left_e  = '0;
			assign left_le = 1'b1;
		end else begin : g_mid
			assign left_e  = entries[i-1];
			assign left_le = le_v[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		msps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_entry (left_e),
			.right_entry(right_e),
			.left_le    (left_le),
			.shift_hit  (pfx_v[i]),
			.entry      (entries[i]),
			.le         (le_v[i]),
			.hit        (hit_v[i])
		);
	end

	// The index is held at most once, so the last prefix bit says present.
	assign present = pfx_v[CAPACITY-1];

	always_comb begin
		state_d    = state_q;
		scan_load  = 1'b0;
		scan_step  = 1'b0;
		ctrl.cmd   = msps_pkg::CMD_HOLD;
		ctrl.key   = item_q.match_index;
		ctrl.score = item_q.match_score;
		count_d    = count_q;
		status_d   = status_q;
		unique case (state_q)
			msps_pkg::S_IDLE: begin
				if (start) begin
					state_d = msps_pkg::S_LOAD;
				end
			end
			msps_pkg::S_LOAD: begin
				scan_load = 1'b1;
				state_d   = msps_pkg::S_SCAN;
			end
			msps_pkg::S_SCAN: begin
				scan_step = 1'b1;
				if (scan_last) begin
					state_d = msps_pkg::S_APPLY;
				end
			end
			msps_pkg::S_APPLY: begin
				state_d  = msps_pkg::S_RESP;
				status_d = msps_pkg::ST_NOEFFECT;
				unique case (item_q.op)
					msps_pkg::OP_INSERT: begin
						if (present) begin
							status_d = msps_pkg::ST_NOEFFECT;
						end else if (count_q == CNT_W'(CAPACITY)) begin
							status_d = msps_pkg::ST_FULL;
						end else begin
							status_d = msps_pkg::ST_DONE;
							ctrl.cmd = msps_pkg::CMD_INSERT;
							count_d  = count_q + CNT_W'(1);
						end
					end
					msps_pkg::OP_ERASE: begin
						if (present) begin
							status_d = msps_pkg::ST_DONE;
							ctrl.cmd = msps_pkg::CMD_ERASE;
							count_d  = count_q - CNT_W'(1);
						end
					end
					msps_pkg::OP_FIND: begin
						status_d = present ? msps_pkg::ST_DONE : msps_pkg::ST_NOEFFECT;
					end
					default: begin
						status_d = msps_pkg::ST_NOEFFECT;
					end
				endcase
			end
			msps_pkg::S_RESP: begin
				state_d = msps_pkg::S_IDLE;
			end
			default: begin
				state_d = msps_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= msps_pkg::S_IDLE;
			count_q  <= '0;
			status_q <= msps_pkg::ST_DONE;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			status_q <= status_d;
			done_q   <= (state_q == msps_pkg::S_RESP);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == msps_pkg::S_IDLE && start) begin
			item_q <= item;
		end
		if (state_q == msps_pkg::S_RESP) begin
			result_q.status      <= status_q;
			result_q.entry_count <= msps_pkg::COUNT_W'(count_q);
			result_q.top_valid   <= entries[0].valid;
			result_q.top_index   <= entries[0].valid ? entries[0].index : '0;
			result_q.top_score   <= entries[0].valid ? entries[0].score : '0;
		end
	end

	assign busy   = (state_q != msps_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result word did not arrive after the fixed latency");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == msps_pkg::S_RESP))
		else $error("done raised outside the response step");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("held count exceeds the cell count");
	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msps_pkg::S_RESP |-> entries[0].valid == (count_q != '0))
		else $error("top cell validity disagrees with the held count");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for min_score_priority_set_top: a queued driver feeds command words,
// a monitor checks each result word against a queue-based model of the sorted set.
// Depends on msps_pkg for the word types and the op and status codes.
module tb;

	localparam int CAPACITY    = msps_pkg::CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;
	localparam int RAND_WORDS  = 950;
	localparam int PHASE_LEN   = 160;
	localparam logic [msps_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              start    = 1'b0;
	logic              busy;
	msps_pkg::item_t   cmd_word = '0;
	logic              done;
	msps_pkg::result_t res_word;

	msps_pkg::item_t   pending_words[$];
	msps_pkg::result_t expected_results[$];

	// Model of the set: cell 0 is the top, scores ascending, ties in insert order.
	logic [msps_pkg::INDEX_W-1:0] model_index[$];
	logic [msps_pkg::SCORE_W-1:0] model_score[$];

	logic taken = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;
	int   cycle_count = 0;
	int   error_count = 0;
	int   checked_count = 0;
	int   stored_count = 0;
	int   erased_count = 0;
	int   refused_full = 0;
	int   peak_fill = 0;

	min_score_priority_set_top #(.CAPACITY(CAPACITY)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (cmd_word),
		.done   (done),
		.result (res_word)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic msps_pkg::result_t step_set_model(msps_pkg::item_t w);
		msps_pkg::result_t r;
		int                pos;
		int                slot;
		pos = -1;
		foreach (model_index[k]) begin
			if (pos < 0 && model_index[k] == w.match_index) pos = k;
		end
		r = '0;
		r.status = msps_pkg::ST_NOEFFECT;
		unique case (w.op)
			msps_pkg::OP_INSERT: begin
				if (pos >= 0) begin
					r.status = msps_pkg::ST_NOEFFECT;
				end else if (model_index.size() >= CAPACITY) begin
					r.status = msps_pkg::ST_FULL;
					refused_full++;
				end else begin
					slot = 0;
					while (slot < model_score.size() && model_score[slot] <= w.match_score)
						slot++;
					model_index.insert(slot, w.match_index);
					model_score.insert(slot, w.match_score);
					r.status = msps_pkg::ST_DONE;
					stored_count++;
				end
			end
			msps_pkg::OP_ERASE: begin
				if (pos >= 0) begin
					model_index.delete(pos);
					model_score.delete(pos);
					r.status = msps_pkg::ST_DONE;
					erased_count++;
				end
			end
			msps_pkg::OP_FIND: begin
				r.status = (pos >= 0) ? msps_pkg::ST_DONE : msps_pkg::ST_NOEFFECT;
			end
			default: ;
		endcase
		if (model_index.size() > peak_fill) peak_fill = model_index.size();
		r.entry_count = msps_pkg::COUNT_W'(model_index.size());
		if (model_index.size() > 0) begin
			r.top_valid = 1'b1;
			r.top_index = model_index[0];
			r.top_score = model_score[0];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: mismatch in %s: expected %0d, actual %0d", $realtime, name,
				want, got);
			error_count++;
		end
	endtask

	function automatic void queue_word(msps_pkg::item_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	// Driver: holds a word until it is taken, then moves on or sits out a gap.
	always @(negedge clk) begin
		if (taken) void'(pending_words.pop_front());
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !taken) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (pending_words.size() > 0) begin
			cmd_word <= pending_words[0];
			start <= 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: checks the result word first, then records a newly taken word.
	always @(posedge clk) begin
		msps_pkg::result_t want;
		cycle_count <= cycle_count + 1;
		taken <= arst_n && start && !busy;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t ns: result word with none expected: actual %h", $realtime,
					res_word);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, res_word.status);
				check_field("entry_count", want.entry_count, res_word.entry_count);
				check_field("top_valid", want.top_valid, res_word.top_valid);
				check_field("top_index", want.top_index, res_word.top_index);
				check_field("top_score", want.top_score, res_word.top_score);
				checked_count++;
			end
		end
		if (arst_n && start && !busy)
			expected_results.insert(expected_results.size(), step_set_model(cmd_word));
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic msps_pkg::item_t make_word(logic [msps_pkg::OP_W-1:0] op,
			logic [msps_pkg::INDEX_W-1:0] idx, logic [msps_pkg::SCORE_W-1:0] score);
		msps_pkg::item_t w;
		w.op = op;
		w.match_index = idx;
		w.match_score = score;
		return w;
	endfunction

	function automatic logic [msps_pkg::SCORE_W-1:0] pick_score();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3) return msps_pkg::SCORE_W'($urandom_range(0, 7));
		if (sel == 3) return '0;
		if (sel == 4) return '1;
		return msps_pkg::SCORE_W'($urandom);
	endfunction

	initial begin
		logic [msps_pkg::INDEX_W-1:0] issued_keys[$];
		logic [msps_pkg::INDEX_W-1:0] key;
		logic [msps_pkg::OP_W-1:0]    op;
		int                           sel;
		int                           pick;
		bit                           growing;

		// Directed words: empty-set cases, extremes, ties, duplicates and the unused op.
		queue_word(make_word(msps_pkg::OP_FIND, 16'h0005, 16'h0000));
		queue_word(make_word(msps_pkg::OP_ERASE, 16'h0005, 16'hFFFF));
		queue_word(make_word(OP_UNUSED, 16'h0005, 16'h0001));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'h0000, 16'h0000));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'h0000, 16'h0064));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'h1234, 16'h0000));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'h00FF, 16'hFFFF));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'hAAAA, 16'h5555));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'h5555, 16'hAAAA));
		queue_word(make_word(msps_pkg::OP_FIND, 16'h1234, 16'hFFFF));
		queue_word(make_word(msps_pkg::OP_FIND, 16'h4321, 16'h0000));
		queue_word(make_word(OP_UNUSED, 16'h1234, 16'hFFFF));
		queue_word(make_word(msps_pkg::OP_ERASE, 16'h0000, 16'h0000));
		queue_word(make_word(msps_pkg::OP_ERASE, 16'h0000, 16'h0000));
		queue_word(make_word(msps_pkg::OP_ERASE, 16'hFFFF, 16'h0000));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'h0000, 16'hFFFF));
		queue_word(make_word(msps_pkg::OP_INSERT, 16'h8000, 16'h8000));
		queue_word(make_word(msps_pkg::OP_FIND, 16'hFFFF, 16'h0000));
		queue_word(make_word(msps_pkg::OP_ERASE, 16'h00FF, 16'h0000));
		queue_word(make_word(msps_pkg::OP_ERASE, 16'h1234, 16'h0000));
		queue_word(make_word(msps_pkg::OP_ERASE, 16'h0000, 16'h0000));

		// Random words in alternating phases: mostly inserts to fill the set up to
		// full, then mostly erases of issued keys to drain it again.
		for (int n = 0; n < RAND_WORDS; n++) begin
			growing = ((n / PHASE_LEN) % 2) == 0;
			sel = $urandom_range(0, 99);
			if (growing)
				op = (sel < 70) ? msps_pkg::OP_INSERT : (sel < 82) ? msps_pkg::OP_ERASE :
					(sel < 96) ? msps_pkg::OP_FIND : OP_UNUSED;
			else
				op = (sel < 20) ? msps_pkg::OP_INSERT : (sel < 82) ? msps_pkg::OP_ERASE :
					(sel < 96) ? msps_pkg::OP_FIND : OP_UNUSED;
			// A small key pool makes duplicate inserts common; the rest roam all bits.
			key = ($urandom_range(0, 3) != 0) ? msps_pkg::INDEX_W'($urandom_range(0, 79)) :
				msps_pkg::INDEX_W'($urandom);
			if (op != msps_pkg::OP_INSERT && issued_keys.size() > 0 &&
					$urandom_range(0, 9) < 8) begin
				pick = $urandom_range(0, issued_keys.size() - 1);
				key = issued_keys[pick];
				if (op == msps_pkg::OP_ERASE) issued_keys.delete(pick);
			end
			if (op == msps_pkg::OP_INSERT) issued_keys.insert(issued_keys.size(), key);
			queue_word(make_word(op, key, pick_score()));
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_words.size() != 0 || start || expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d result words: %0d inserts stored, %0d erases done,",
			checked_count, stored_count, erased_count);
		$display("%0d inserts refused on a full set, peak fill %0d of %0d cells.",
			refused_full, peak_fill, CAPACITY);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
